// ----- hw/rtl/hbsfc_pkg.sv -----
// Package: format codes and conversion helper functions for the format converter.
`default_nettype none
package hbsfc_pkg;

  typedef enum logic [1:0] {
    FMT_FP32 = 2'd0,
    FMT_FP16 = 2'd1,
    FMT_BF16 = 2'd2,
    FMT_NONE = 2'd3
  } fmt_t;

  localparam logic CFG_SRC = 1'b0;
  localparam logic CFG_DST = 1'b1;

  // Widen an FP16 pattern to FP32; subnormals normalized by leading-zero count.
  function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
    logic [9:0]  man;
    logic [4:0]  ex;
    logic [3:0]  lz;
    logic [9:0]  nman;
    logic [7:0]  nexp;
    logic        found;
    logic [31:0] res;
    man   = h[9:0];
    ex    = h[14:10];
    lz    = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found && man[i]) begin
        found = 1'b1;
        lz    = 4'(9 - i);
      end
    end
    nman = 10'(man << (lz + 4'd1));
    nexp = 8'(8'd113 - {4'd0, lz} - 8'd1);
    if (ex == 5'd0) begin
      if (man == 10'd0) res = {h[15], 31'd0};
      else res = {h[15], nexp, nman, 13'd0};
    end else if (ex == 5'h1F) begin
      res = {h[15], 8'hFF, man, 13'd0};
    end else begin
      res = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
    return res;
  endfunction

  // Round FP32 to BF16, nearest even, no NaN guard.
  function automatic logic [15:0] fp32_to_bf16(input logic [31:0] w);
    logic [31:0] sum;
    sum = w + 32'h0000_7FFF + {31'd0, w[16]};
    return sum[31:16];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/half_bfloat_single_format_converter.sv -----
// Top level: pipelined FP32 / FP16 / BF16 element format converter.
//
// Usage: elements enter on the in_ stream (tdata = source_bits, tlast = last_in)
// and leave on the out_ stream (tdata = result_bits, tlast = last_out), one
// result per element, in order. The cfg_ port writes source_format (index 0)
// and target_format (index 1); write only while the stream is drained.
// Path: an accepted beat passes the stage 1 to stage 4 registers in order
// before its result can be taken on the out_ stream.
// Throughput: one beat per cycle while no stall holds the stages; four register stages (widen to FP32,
// FP16 field split, mantissa round, result select) each take a beat a cycle.
// Stall: when out_tready is low, only a full pipeline holds; stages fill bubbles
// first, so in_tready stays high until every stage holds a beat.
// Reset: both format registers return to FP32 and all stage valid bits clear.
// Format code 3 on either side yields zero data with tlast still copied.
`default_nettype none
module half_bfloat_single_format_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] source_bits
  input  wire logic        in_tlast,   // last_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] result_bits
  output logic             out_tlast,  // last_out
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [1:0]  cfg_wdata
);

  logic [1:0] src_r, dst_r;

  // Format registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= hbsfc_pkg::FMT_FP32;
      dst_r <= hbsfc_pkg::FMT_FP32;
    end else if (cfg_we) begin
      if (cfg_addr == hbsfc_pkg::CFG_SRC) src_r <= cfg_wdata;
      else src_r <= src_r;
      if (cfg_addr == hbsfc_pkg::CFG_DST) dst_r <= cfg_wdata;
      else dst_r <= dst_r;
    end
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  assign en4 = out_tready || !v4_r;
  assign en3 = en4 || !v3_r;
  assign en2 = en3 || !v2_r;
  assign en1 = en2 || !v1_r;
  assign in_tready = en1;

  // Stage 1: widen source to FP32 (or keep pass-through data).
  logic [31:0] w1_r, w1_nxt;
  logic [15:0] p1_r;
  logic        l1_r, pass1_r, bad1_r;
  logic        pass1_nxt, bad1_nxt;
  always_comb begin
    bad1_nxt  = (src_r == hbsfc_pkg::FMT_NONE) || (dst_r == hbsfc_pkg::FMT_NONE);
    pass1_nxt = (src_r == dst_r);
    case (src_r)
      hbsfc_pkg::FMT_FP16: w1_nxt = hbsfc_pkg::fp16_to_fp32(in_tdata[15:0]);
      hbsfc_pkg::FMT_BF16: w1_nxt = {in_tdata[15:0], 16'd0};
      default:             w1_nxt = in_tdata;
    endcase
    if (pass1_nxt && src_r == hbsfc_pkg::FMT_FP32) w1_nxt = in_tdata;
  end
  always_ff @(posedge clk) begin
    if (en1) begin
      w1_r    <= w1_nxt;
      p1_r    <= in_tdata[15:0];
      l1_r    <= in_tlast;
      pass1_r <= pass1_nxt;
      bad1_r  <= bad1_nxt;
    end
  end

  // Stage 2: split FP32 into FP16 fields and compute BF16 rounding.
  logic [31:0] w2_r;
  logic [15:0] bf2_r;
  logic signed [9:0] e2_r;
  logic [22:0] m2_r;
  logic [15:0] p2_r;
  logic        l2_r, pass2_r, bad2_r;
  always_ff @(posedge clk) begin
    if (en2) begin
      w2_r    <= w1_r;
      bf2_r   <= hbsfc_pkg::fp32_to_bf16(w1_r);
      e2_r    <= $signed({2'b00, w1_r[30:23]}) - 10'sd112;
      m2_r    <= w1_r[22:0];
      p2_r    <= p1_r;
      l2_r    <= l1_r;
      pass2_r <= pass1_r;
      bad2_r  <= bad1_r;
    end
  end

  // Stage 3: FP16 round / subnormal shift.
  logic [15:0] h3_r, h3_nxt;
  logic [15:0] bf3_r, p3_r;
  logic [31:0] w3_r;
  logic        l3_r, pass3_r, bad3_r;
  logic [23:0] sm;
  logic [23:0] rm;
  logic [14:0] rsum;
  logic [4:0]  sh;
  always_comb begin
    sh   = 5'(10'sd1 - e2_r);
    sm   = {1'b1, m2_r} >> sh;
    rm   = {1'b0, m2_r} + 24'h000FFF + {23'd0, m2_r[13]};
    rsum = 15'({e2_r[4:0], 10'd0} + {4'd0, rm[23:13]});
    if (e2_r <= 10'sd0) begin
      if (e2_r < -10'sd10) h3_nxt = {w2_r[31], 15'd0};
      else h3_nxt = {w2_r[31], 5'd0, sm[22:13]};
    end else if (e2_r >= 10'sd31) begin
      h3_nxt = {w2_r[31], 15'h7C00};
    end else begin
      h3_nxt = {w2_r[31], rsum};
    end
  end
  always_ff @(posedge clk) begin
    if (en3) begin
      h3_r    <= h3_nxt;
      bf3_r   <= bf2_r;
      p3_r    <= p2_r;
      w3_r    <= w2_r;
      l3_r    <= l2_r;
      pass3_r <= pass2_r;
      bad3_r  <= bad2_r;
    end
  end

  // Stage 4: select result by target format.
  logic [31:0] r4_r, r4_nxt;
  logic        l4_r;
  always_comb begin
    if (bad3_r) r4_nxt = 32'd0;
    else if (pass3_r) r4_nxt = (dst_r == hbsfc_pkg::FMT_FP32) ? w3_r : {16'd0, p3_r};
    else begin
      case (dst_r)
        hbsfc_pkg::FMT_FP16: r4_nxt = {16'd0, h3_r};
        hbsfc_pkg::FMT_BF16: r4_nxt = {16'd0, bf3_r};
        default:             r4_nxt = w3_r;
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (en4) begin
      r4_r <= r4_nxt;
      l4_r <= l3_r;
    end
  end

  // Advance valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = r4_r;
  assign out_tlast  = l4_r;

`ifndef ASSERT_OFF
  // A stalled full pipeline must refuse input.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline full and stalled");
  // A held output beat keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output beat changed under stall");
  // Invalid format codes give zero data.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en4 && v3_r && bad3_r) |=> (out_tdata == 32'd0))
    else $error("invalid format produced data");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_half_bfloat_single_format_converter.sv -----
// Testbench for the FP32 / FP16 / BF16 element format converter.
`timescale 1ns / 1ps
`default_nettype none
module tb_half_bfloat_single_format_converter;

  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } elem_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_addr;
  logic [1:0]  cfg_wdata;

  // formats as last written, tracked by the converter model
  hbsfc_pkg::fmt_t src_fmt;
  hbsfc_pkg::fmt_t dst_fmt;
  elem_t converted_q[$];
  int    errors;
  int    idle_cycles;
  int    send_idle_pct;
  int    recv_stall_pct;

  half_bfloat_single_format_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [31:0] source_bits
    .in_tlast  (in_tlast),   // last_in
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [31:0] result_bits
    .out_tlast (out_tlast),  // last_out
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Widen half precision to single, normalizing subnormals.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [10:0] man;
    int          shifts;
    sgn = {h[15], 31'd0};
    ex  = h[14:10];
    man = {1'b0, h[9:0]};
    shifts = 0;
    if (ex == 5'd0) begin
      if (man == 11'd0) return sgn;
      while (!man[10]) begin
        man = man << 1;
        shifts++;
      end
      return sgn | (32'(113 - shifts) << 23) | (32'(man[9:0]) << 13);
    end
    if (ex == 5'h1F) return sgn | 32'h7F80_0000 | (32'(man[9:0]) << 13);
    return sgn | (32'(ex + 112) << 23) | (32'(man[9:0]) << 13);
  endfunction

  // Narrow single to bfloat with round to nearest even.
  function automatic logic [31:0] narrow_bfloat(input logic [31:0] w);
    logic [31:0] sum;
    sum = w + 32'h0000_7FFF + {31'd0, w[16]};
    return {16'd0, sum[31:16]};
  endfunction

  // Narrow single to half: round normals, truncate subnormals, saturate to inf.
  function automatic logic [31:0] narrow_half(input logic [31:0] w);
    logic [31:0] sgn;
    int          ex;
    logic [31:0] man;
    sgn = (w & 32'h8000_0000) >> 16;
    ex  = int'(w[30:23]) - 112;
    man = w & 32'h007F_FFFF;
    if (ex <= 0) begin
      if (ex < -10) return sgn;
      man = (man | 32'h0080_0000) >> (1 - ex);
      return sgn | (man >> 13);
    end
    if (ex >= 31) return sgn | 32'h7C00;
    man = man + 32'h0FFF + ((man >> 13) & 32'd1);
    return sgn | (((32'(ex) << 10) + (man >> 13)) & 32'h7FFF);
  endfunction

  function automatic logic [31:0] convert_elem(input logic [31:0] bits);
    logic [15:0] low;
    low = bits[15:0];
    if (src_fmt == hbsfc_pkg::FMT_NONE || dst_fmt == hbsfc_pkg::FMT_NONE) return 32'd0;
    if (src_fmt == dst_fmt)
      return (src_fmt == hbsfc_pkg::FMT_FP32) ? bits : {16'd0, low};
    if (src_fmt == hbsfc_pkg::FMT_BF16 && dst_fmt == hbsfc_pkg::FMT_FP32)
      return {low, 16'd0};
    if (src_fmt == hbsfc_pkg::FMT_FP32 && dst_fmt == hbsfc_pkg::FMT_BF16)
      return narrow_bfloat(bits);
    if (src_fmt == hbsfc_pkg::FMT_FP16 && dst_fmt == hbsfc_pkg::FMT_FP32)
      return widen_half(low);
    if (src_fmt == hbsfc_pkg::FMT_FP32 && dst_fmt == hbsfc_pkg::FMT_FP16)
      return narrow_half(bits);
    if (src_fmt == hbsfc_pkg::FMT_BF16) return narrow_half({low, 16'd0});
    return narrow_bfloat(widen_half(low));
  endfunction

  // Send one beat, waiting out the random sender gap first.
  task automatic send_elem(input logic [31:0] bits, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk);
      in_tvalid <= 1'b0;
    end
    @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    in_tlast  <= last;
    converted_q.push_back('{convert_elem(bits), last});
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
  endtask

  // Drain the pipeline, then write both format registers.
  task automatic set_formats(input hbsfc_pkg::fmt_t src, input hbsfc_pkg::fmt_t dst);
    while (converted_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= hbsfc_pkg::CFG_SRC;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_addr  <= hbsfc_pkg::CFG_DST;
    cfg_wdata <= dst;
    @(posedge clk);
    cfg_we    <= 1'b0;
    src_fmt = src;
    dst_fmt = dst;
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // Random pattern biased toward FP32 and FP16 exponent edges and FP16 rounding boundaries.
  function automatic logic [31:0] rand_operand();
    logic [31:0] w;
    w = rand_word();
    case ($urandom_range(5))
      0: w[30:23] = 8'(112 + $urandom_range(0, 3));
      1: w[30:23] = 8'(143 - $urandom_range(0, 2));
      2: w[30:23] = 8'(102 + $urandom_range(0, 10));
      3: w[14:10] = ($urandom_range(1)) ? 5'd0 : 5'h1F;
      4: w[12:0]  = ($urandom_range(1)) ? 13'h1000 : 13'h0FFF;
      default: ;
    endcase
    return w;
  endfunction

  // Formats out of reset pass FP32 through.
  task automatic test_reset_formats();
    send_elem(32'hDEAD_BEEF, 1'b1);
  endtask

  task automatic test_directed_edges();
    logic [31:0] pats[$];
    pats = {32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7F80_0000,
            32'h7FC0_0001, 32'h477F_F000, 32'h477F_EFFF, 32'h4780_0000,
            32'h3880_0000, 32'h387F_FFFF, 32'h3300_0000, 32'h32FF_FFFF,
            32'h3F80_8000, 32'h3F81_8000, 32'hABCD_0001, 32'h0000_03FF,
            32'h0000_8001, 32'h0000_7C00, 32'h0000_7E01, 32'h0000_FBFF,
            32'h1234_0400, 32'h5555_AAAA, 32'hAAAA_5555};
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 4; d++) begin
        set_formats(hbsfc_pkg::fmt_t'(s), hbsfc_pkg::fmt_t'(d));
        foreach (pats[i]) send_elem(pats[i], i[0]);
      end
    end
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        set_formats(hbsfc_pkg::fmt_t'($urandom_range(2)),
                    hbsfc_pkg::fmt_t'($urandom_range(2)));
      send_elem(rand_operand(), $urandom_range(1));
    end
  endtask

  // Stall the result side at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    elem_t exp_elem;
    if (rst_n && out_tvalid && out_tready) begin
      if (converted_q.size() == 0) begin
        $display("%0t: unexpected beat data=%h last=%b", $time, out_tdata, out_tlast);
        errors++;
      end else begin
        exp_elem = converted_q.pop_front();
        if (out_tdata !== exp_elem.bits) begin
          $display("%0t: result_bits expected %h actual %h", $time,
                   exp_elem.bits, out_tdata);
          errors++;
        end
        if (out_tlast !== exp_elem.last) begin
          $display("%0t: last_out expected %b actual %b", $time,
                   exp_elem.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Abort when no beat moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb_half_bfloat_single_format_converter: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = hbsfc_pkg::CFG_SRC;
    cfg_wdata      = hbsfc_pkg::FMT_FP32;
    src_fmt        = hbsfc_pkg::FMT_FP32;
    dst_fmt        = hbsfc_pkg::FMT_FP32;
    errors         = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_formats();
    test_directed_edges();
    test_random_phase(0, 0, 220);
    test_random_phase(53, 0, 220);
    test_random_phase(0, 53, 220);
    test_random_phase(15, 15, 220);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (converted_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_half_bfloat_single_format_converter: done, clean");
    end else begin
      $display("tb_half_bfloat_single_format_converter: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- half_bfloat_single_format_converter.f -----
hw/rtl/hbsfc_pkg.sv
hw/rtl/half_bfloat_single_format_converter.sv
dv/tb_half_bfloat_single_format_converter.sv
